// ===== design/cmtt_pkg.sv =====
// Shared types, codes and sizing constants for the CAN message tracker table.
`timescale 1ns / 1ps
package cmtt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int PAYLOAD_BYTES = 8;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ACT_W = $clog2(TABLE_ENTRIES + 1);

    // fixed field widths
    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 16;
    localparam int LEN_W    = 4;
    localparam int DATA_W   = 64;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 3;
    localparam int ACTIVE_W = 5;
    localparam int HITS_W   = 8;

    localparam logic [HITS_W-1:0] HIT_MAX = 8'hFF;
    localparam logic [LEN_W-1:0]  LEN_MAX = LEN_W'(PAYLOAD_BYTES);

    // function codes
    localparam logic [FUNC_W-1:0] FN_RECORD = 2'd0;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NONE   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROP  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEAR = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  can_id;
        logic [KEY_W-1:0]  unique_id;
        logic [LEN_W-1:0]  payload_len;
        logic [DATA_W-1:0] payload;
        logic [SLOT_W-1:0] read_slot;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [ACTIVE_W-1:0] active_count;
        logic [KEY_W-1:0]    entry_id;
        logic [KEY_W-1:0]    entry_unique;
        logic [HITS_W-1:0]   entry_hits;
        logic [LEN_W-1:0]    entry_len;
        logic [DATA_W-1:0]   entry_payload;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture the incoming transfer, restart the scan
        logic scan;    // examine one entry
        logic update;  // pick the slot and write it
        logic clear;   // interval end
        logic emit;    // load the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== design/can_message_tracker_table.sv =====
// Top level of the CAN message tracker table: controller plus table datapath.
`timescale 1ns / 1ps
// Keeps 16 entries keyed by (can_id, unique_id). One transfer in, at most one
// result out. A record transfer keeps the block busy through its capture on
// acceptance, a scan that walks the table one entry per cycle through its
// single read port (first key match, first and second zero-count entries),
// an update of the chosen slot and the load of the output register, which
// raises o_out_valid. A read goes from capture to the output register load,
// and an interval end clears the counts before that load; func code 3 is
// accepted and dropped with no result. Only one transfer is in work at a
// time: o_in_stall is high from acceptance until the result is in the output
// register, and longer while the output register still holds an older result
// under i_out_stall. The output register parts the two sides, so the next
// transfer is accepted while a result still waits on i_out_stall. Entry 0
// starts with key zero, so a zero key after reset reports a hit. Lengths
// above 8 are saturated to 8. All table state is cleared by reset.
module can_message_tracker_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cmtt_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cmtt_pkg::t_out_item  o_out_item
);
    import cmtt_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencing: idle / scan / update / clear / result
    cmtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_item.func),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // entry table, scan trackers and output register
    cmtt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== design/cmtt_ctrl.sv =====
// Sequencing state machine for the CAN message tracker table.
`timescale 1ns / 1ps
module cmtt_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [cmtt_pkg::FUNC_W-1:0]  i_func,
    input  cmtt_pkg::t_dp_status         i_status,
    output logic                         o_in_stall,
    output cmtt_pkg::t_dp_cmd            o_cmd
);
    import cmtt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_CLEAR  = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_func)
                        FN_RECORD: n_state = S_SCAN;
                        FN_READ:   n_state = S_RESULT;
                        FN_CLEAR:  n_state = S_CLEAR;
                        FN_NONE:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_RESULT;
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/cmtt_datapath.sv =====
// Entry table, scan tracking and output register of the CAN message tracker table.
`timescale 1ns / 1ps
module cmtt_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cmtt_pkg::t_in_item    i_in_item,
    input  cmtt_pkg::t_dp_cmd     i_cmd,
    output cmtt_pkg::t_dp_status  o_status,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output cmtt_pkg::t_out_item   o_out_item
);
    import cmtt_pkg::*;

    // entry storage
    logic [KEY_W-1:0]  r_key_id     [TABLE_ENTRIES];
    logic [KEY_W-1:0]  r_key_unique [TABLE_ENTRIES];
    logic [LEN_W-1:0]  r_len        [TABLE_ENTRIES];
    logic [HITS_W-1:0] r_hits       [TABLE_ENTRIES];
    logic [DATA_W-1:0] r_payload    [TABLE_ENTRIES];
    logic [ACT_W-1:0]  r_active;

    // captured transfer and scan results
    t_in_item          r_item;
    logic [IDX_W-1:0]  r_idx;
    logic              r_hit_found;
    logic [IDX_W-1:0]  r_hit_idx;
    logic              r_z1_found;
    logic [IDX_W-1:0]  r_z1;
    logic              r_z2_found;
    logic [IDX_W-1:0]  r_z2;

    // result bookkeeping
    logic [IDX_W-1:0]    r_sel;
    logic [SLOT_W-1:0]   r_slot;
    logic [STATUS_W-1:0] r_status;
    logic                r_show;

    t_out_item r_out;
    logic      r_out_valid;

    logic [IDX_W-1:0]  w_sel;
    logic              w_drop;
    logic [IDX_W-1:0]  w_rd_addr;
    logic [KEY_W-1:0]  w_rd_id;
    logic [KEY_W-1:0]  w_rd_unique;
    logic [LEN_W-1:0]  w_rd_len;
    logic [HITS_W-1:0] w_rd_hits;
    logic [DATA_W-1:0] w_rd_payload;
    logic              w_match;
    logic              w_zero;
    logic [LEN_W-1:0]  w_len_sat;
    logic [HITS_W-1:0] w_hits_inc;
    logic [DATA_W-1:0] w_new_payload;
    logic [ACT_W-1:0]  w_active_upd;

    assign w_sel  = r_hit_found ? r_hit_idx : r_z1;
    assign w_drop = !r_hit_found && !r_z1_found;

    // single read address: scan pointer, chosen slot during update, else result slot
    always_comb begin
        if (i_cmd.scan) begin
            w_rd_addr = r_idx;
        end else if (i_cmd.update) begin
            w_rd_addr = w_sel;
        end else begin
            w_rd_addr = r_sel;
        end
    end

    assign w_rd_id      = r_key_id[w_rd_addr];
    assign w_rd_unique  = r_key_unique[w_rd_addr];
    assign w_rd_len     = r_len[w_rd_addr];
    assign w_rd_hits    = r_hits[w_rd_addr];
    assign w_rd_payload = r_payload[w_rd_addr];

    assign w_match = (w_rd_id == r_item.can_id) && (w_rd_unique == r_item.unique_id);
    assign w_zero  = (w_rd_hits == '0);

    assign w_len_sat  = (r_item.payload_len > LEN_MAX) ? LEN_MAX : r_item.payload_len;
    assign w_hits_inc = (w_rd_hits == HIT_MAX) ? w_rd_hits : w_rd_hits + 8'd1;

    // merge the first w_len_sat bytes over the stored payload
    always_comb begin
        for (int b = 0; b < DATA_W / 8; b++) begin
            if (LEN_W'(b) < w_len_sat) begin
                w_new_payload[b*8 +: 8] = r_item.payload[b*8 +: 8];
            end else begin
                w_new_payload[b*8 +: 8] = w_rd_payload[b*8 +: 8];
            end
        end
    end

    // first zero-count entry once the chosen slot has counted this packet
    always_comb begin
        if (r_z1_found && w_zero && (w_sel == r_z1)) begin
            w_active_upd = r_z2_found ? ACT_W'(r_z2) : ACT_W'(TABLE_ENTRIES);
        end else begin
            w_active_upd = r_z1_found ? ACT_W'(r_z1) : ACT_W'(TABLE_ENTRIES);
        end
    end

    // table and first zero-count index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_key_id[i]     <= '0;
                r_key_unique[i] <= '0;
                r_len[i]        <= '0;
                r_hits[i]       <= '0;
                r_payload[i]    <= '0;
            end
            r_active <= '0;
        end else if (i_cmd.update) begin
            if (!w_drop) begin
                r_key_id[w_sel]     <= r_item.can_id;
                r_key_unique[w_sel] <= r_item.unique_id;
                r_len[w_sel]        <= w_len_sat;
                r_hits[w_sel]       <= w_hits_inc;
                r_payload[w_sel]    <= w_new_payload;
                r_active            <= w_active_upd;
            end
        end else if (i_cmd.clear) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (r_hits[i] == '0) begin
                    r_key_id[i]     <= '0;
                    r_key_unique[i] <= '0;
                end
                r_hits[i] <= '0;
            end
            r_active <= '0;
        end
    end

    // scan tracking: first key match, first and second zero-count entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_hit_found <= 1'b0;
            r_z1_found  <= 1'b0;
            r_z2_found  <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx       <= '0;
            r_hit_found <= 1'b0;
            r_z1_found  <= 1'b0;
            r_z2_found  <= 1'b0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + 1'b1;
            if (w_match && !r_hit_found) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_idx;
            end
            if (w_zero) begin
                if (!r_z1_found) begin
                    r_z1_found <= 1'b1;
                    r_z1       <= r_idx;
                end else if (!r_z2_found) begin
                    r_z2_found <= 1'b1;
                    r_z2       <= r_idx;
                end
            end
        end
    end

    // captured transfer and result bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item   <= i_in_item;
            r_sel    <= IDX_W'(i_in_item.read_slot);
            r_slot   <= i_in_item.read_slot;
            r_status <= ST_READ;
            r_show   <= (int'(i_in_item.read_slot) < TABLE_ENTRIES);
        end else if (i_cmd.update) begin
            r_sel <= w_sel;
            if (w_drop) begin
                r_status <= ST_DROP;
                r_slot   <= '0;
                r_show   <= 1'b0;
            end else begin
                r_status <= r_hit_found ? ST_HIT : ST_NEW;
                r_slot   <= SLOT_W'(w_sel);
                r_show   <= 1'b1;
            end
        end else if (i_cmd.clear) begin
            r_status <= ST_CLEAR;
            r_slot   <= '0;
            r_show   <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.status        <= r_status;
            r_out.slot          <= r_slot;
            r_out.active_count  <= ACTIVE_W'(r_active);
            r_out.entry_id      <= r_show ? w_rd_id      : '0;
            r_out.entry_unique  <= r_show ? w_rd_unique  : '0;
            r_out.entry_hits    <= r_show ? w_rd_hits    : '0;
            r_out.entry_len     <= r_show ? w_rd_len     : '0;
            r_out.entry_payload <= r_show ? w_rd_payload : '0;
        end
    end

    assign o_status.scan_last = (r_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

endmodule

// ===== design/cmtt_props.sv =====
// Port-level assertions for the CAN message tracker table, bound to the top level.
`timescale 1ns / 1ps
module cmtt_props (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input cmtt_pkg::t_in_item   i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input cmtt_pkg::t_out_item  o_out_item
);
    import cmtt_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or vanished");

    // one transfer in work at a time: a real command blocks the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.func != FN_NONE) |=> o_in_stall)
        else $error("input accepted while a transfer is still in work");

    // a recorded packet is always counted in its entry
    a_record_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_item.status == ST_HIT) || (o_out_item.status == ST_NEW))
        |-> (o_out_item.entry_hits != '0))
        else $error("recorded entry shows zero count");

    // a dropped packet shows no entry
    a_drop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_DROP)
        |-> (o_out_item.slot == '0) && (o_out_item.entry_hits == '0)
            && (o_out_item.active_count == ACTIVE_W'(TABLE_ENTRIES)))
        else $error("drop result carries entry data");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind can_message_tracker_table cmtt_props u_props (.*);

// ===== test/can_message_tracker_table_tb.sv =====
// Self-checking testbench for the CAN message tracker table: directed rows, then random traffic.
`timescale 1ns / 1ps
module can_message_tracker_table_tb;
    import cmtt_pkg::*;

    localparam int RAND_ITEMS     = 1700;  // counted random transfers (ignored func not counted)
    localparam int HOLD_CYCLES    = 300;   // one long receiver hold-off
    localparam int DRAIN_CYCLES   = 40;    // outlasts the record path, leave margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer on either side
    localparam int POOL_SIZE      = 24;    // more keys than entries, so the table fills
    localparam int REPORT_LIMIT   = 10;

    // traffic mixes for the random chunks
    typedef enum int {
        MIX_FILL,   // pooled keys, no interval end: fills the table, drops
        MIX_CHURN,  // pooled keys with frequent interval ends
        MIX_WIDE,   // half fresh keys, rare interval ends
        MIX_SAT     // one key hammered to push its count to the ceiling
    } t_mix;

    typedef struct {
        t_in_item  frame;
        bit        has_want;  // expected result typed into the row
        t_out_item want;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    can_message_tracker_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // 12 ns clock, starts low so the first rising edge is at 6 ns
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the table, updated at each accepted input transfer
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]  shadow_id   [TABLE_ENTRIES];
    logic [KEY_W-1:0]  shadow_uid  [TABLE_ENTRIES];
    logic [LEN_W-1:0]  shadow_len  [TABLE_ENTRIES];
    logic [HITS_W-1:0] shadow_hits [TABLE_ENTRIES];
    logic [DATA_W-1:0] shadow_data [TABLE_ENTRIES];
    int                shadow_free;  // first zero-count index, TABLE_ENTRIES if none

    t_out_item report_q[$];   // results owed by the block, oldest first
    t_stim_row dir_rows[$];
    logic [31:0] key_pool[POOL_SIZE];

    bit calm;       // no idling on either side for this chunk
    bit hold_req;   // ask the receiver for one long hold-off

    int mismatches;
    int results_seen;
    int frames_in;
    int n_record, n_read, n_clear, n_ignored, n_drop, n_ceiling;

    function automatic t_in_item mk_frame(input logic [FUNC_W-1:0] fn,
                                          input logic [KEY_W-1:0]  cid,
                                          input logic [KEY_W-1:0]  uid,
                                          input logic [LEN_W-1:0]  len,
                                          input logic [DATA_W-1:0] data,
                                          input logic [SLOT_W-1:0] rslot);
        t_in_item f;
        f.func        = fn;
        f.can_id      = cid;
        f.unique_id   = uid;
        f.payload_len = len;
        f.payload     = data;
        f.read_slot   = rslot;
        return f;
    endfunction

    function automatic t_out_item mk_report(input logic [STATUS_W-1:0] st,
                                            input logic [SLOT_W-1:0]   sl,
                                            input logic [ACTIVE_W-1:0] act,
                                            input logic [KEY_W-1:0]    id,
                                            input logic [KEY_W-1:0]    uid,
                                            input logic [HITS_W-1:0]   hits,
                                            input logic [LEN_W-1:0]    len,
                                            input logic [DATA_W-1:0]   data);
        t_out_item r;
        r.status        = st;
        r.slot          = sl;
        r.active_count  = act;
        r.entry_id      = id;
        r.entry_unique  = uid;
        r.entry_hits    = hits;
        r.entry_len     = len;
        r.entry_payload = data;
        return r;
    endfunction

    function automatic string fmt_report(input t_out_item r);
        return $sformatf("st=%0d slot=%0d act=%0d id=%h uid=%h hits=%0d len=%0d data=%h",
                         r.status, r.slot, r.active_count, r.entry_id, r.entry_unique,
                         r.entry_hits, r.entry_len, r.entry_payload);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_row(input t_in_item f, input bit has_want, input t_out_item want);
        t_stim_row row;
        row.frame    = f;
        row.has_want = has_want;
        row.want     = want;
        dir_rows.push_back(row);
    endtask

    // Table update for one accepted transfer; returns the result it owes.
    task automatic apply_frame(input t_in_item it, output bit owes, output t_out_item rep);
        int               hit_idx;
        int               free_idx;
        int               pick;
        logic [LEN_W-1:0] n;
        logic [DATA_W-1:0] mask;
        rep  = '0;
        owes = 1'b1;
        case (it.func)
            FN_RECORD: begin
                n_record++;
                hit_idx  = -1;
                free_idx = -1;
                // first key match wins, even on an entry idle since the last interval
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (hit_idx < 0 && shadow_id[i] == it.can_id
                            && shadow_uid[i] == it.unique_id)
                        hit_idx = i;
                    if (free_idx < 0 && shadow_hits[i] == '0)
                        free_idx = i;
                end
                if (hit_idx < 0 && free_idx < 0) begin
                    // table full: nothing changes, only the active count is reported
                    n_drop++;
                    rep.status       = ST_DROP;
                    rep.active_count = ACTIVE_W'(shadow_free);
                end else begin
                    pick = (hit_idx >= 0) ? hit_idx : free_idx;
                    rep.status = (hit_idx >= 0) ? ST_HIT : ST_NEW;
                    n = (it.payload_len > LEN_MAX) ? LEN_MAX : it.payload_len;
                    mask = (n >= LEN_MAX) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
                    shadow_id[pick]   = it.can_id;
                    shadow_uid[pick]  = it.unique_id;
                    shadow_len[pick]  = n;
                    if (shadow_hits[pick] != HIT_MAX)
                        shadow_hits[pick] = shadow_hits[pick] + 1'b1;
                    if (shadow_hits[pick] == HIT_MAX)
                        n_ceiling++;
                    shadow_data[pick] = (shadow_data[pick] & ~mask) | (it.payload & mask);
                    shadow_free = TABLE_ENTRIES;
                    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                        if (shadow_hits[i] == '0)
                            shadow_free = i;
                    end
                    rep.slot          = SLOT_W'(pick);
                    rep.active_count  = ACTIVE_W'(shadow_free);
                    rep.entry_id      = shadow_id[pick];
                    rep.entry_unique  = shadow_uid[pick];
                    rep.entry_hits    = shadow_hits[pick];
                    rep.entry_len     = shadow_len[pick];
                    rep.entry_payload = shadow_data[pick];
                end
            end
            FN_READ: begin
                n_read++;
                rep.status        = ST_READ;
                rep.slot          = it.read_slot;
                rep.active_count  = ACTIVE_W'(shadow_free);
                rep.entry_id      = shadow_id[it.read_slot];
                rep.entry_unique  = shadow_uid[it.read_slot];
                rep.entry_hits    = shadow_hits[it.read_slot];
                rep.entry_len     = shadow_len[it.read_slot];
                rep.entry_payload = shadow_data[it.read_slot];
            end
            FN_CLEAR: begin
                // idle entries lose their key, every count goes to zero
                n_clear++;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (shadow_hits[i] == '0) begin
                        shadow_id[i]  = '0;
                        shadow_uid[i] = '0;
                    end
                    shadow_hits[i] = '0;
                end
                shadow_free = 0;
                rep.status  = ST_CLEAR;
            end
            default: begin
                n_ignored++;
                owes = 1'b0;
            end
        endcase
    endtask

    // Offer one transfer and hold it until accepted. Valid stays high on return,
    // so a back-to-back transfer never drops it.
    task automatic offer(input t_in_item it, input bit has_want, input t_out_item want);
        bit        owes;
        t_out_item rep;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        apply_frame(it, owes, rep);
        if (owes)
            report_q.push_back(has_want ? want : rep);
        frames_in++;
    endtask

    task automatic sender_gap();
        int g;
        g = calm ? 0 : pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Sender goes quiet until every owed result is back.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (report_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_in_item rand_frame(input t_mix mix);
        t_in_item    f;
        int          r;
        int          clear_pct;
        logic [31:0] key;
        f.payload     = {$urandom, $urandom};
        f.payload_len = LEN_W'($urandom_range(0, 15));
        f.read_slot   = SLOT_W'($urandom_range(0, 15));
        key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        case (mix)
            MIX_SAT:   key = key_pool[0];
            MIX_WIDE:  if ($urandom_range(0, 1) == 0) key = $urandom;
            default:   if ($urandom_range(0, 9) == 0) key = $urandom;
        endcase
        f.can_id    = key[31:16];
        f.unique_id = key[15:0];
        case (mix)
            MIX_CHURN: clear_pct = 8;
            MIX_WIDE:  clear_pct = 3;
            default:   clear_pct = 0;
        endcase
        r = $urandom_range(0, 99);
        if (r < clear_pct)
            f.func = FN_CLEAR;
        else if (r < clear_pct + 4 && mix != MIX_SAT)
            f.func = FN_NONE;
        else if (r < clear_pct + 18)
            f.func = FN_READ;
        else
            f.func = FN_RECORD;
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: checks each output transfer, then picks next cycle's stall
    // ------------------------------------------------------------------
    initial begin : receiver
        int        burst;
        t_out_item want;
        burst       = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                results_seen++;
                if (report_q.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("tb: unexpected result %s", fmt_report(o_out_item));
                    mismatches++;
                end else begin
                    want = report_q.pop_front();
                    if (o_out_item.status !== want.status
                            || o_out_item.slot !== want.slot
                            || o_out_item.active_count !== want.active_count
                            || o_out_item.entry_id !== want.entry_id
                            || o_out_item.entry_unique !== want.entry_unique
                            || o_out_item.entry_hits !== want.entry_hits
                            || o_out_item.entry_len !== want.entry_len
                            || o_out_item.entry_payload !== want.entry_payload) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("tb: mismatch on result %0d", results_seen);
                            $display("    expected %s", fmt_report(want));
                            $display("    actual   %s", fmt_report(o_out_item));
                        end
                        mismatches++;
                    end
                end
            end
            // long hold-off: the block parks one result, takes one more transfer, and
            // then has to stall its input while the sender keeps offering
            if (hold_req) begin
                hold_req = 1'b0;
                burst    = HOLD_CYCLES;
            end else if (burst == 0 && !calm) begin
                burst = pick_gap();
            end
            if (burst > 0) begin
                i_out_stall <= 1'b1;
                burst--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run when neither side moves for too long.
    int idle_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: no transfer for %0d cycles, %0d results still owed",
                         idle_cycles, report_q.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main
        int        counted;
        int        chunk;
        int        chunk_len;
        t_mix      mix;
        t_in_item  f;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        mismatches  = 0;
        results_seen = 0;
        frames_in   = 0;
        n_record = 0; n_read = 0; n_clear = 0; n_ignored = 0; n_drop = 0; n_ceiling = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            shadow_id[i]   = '0;
            shadow_uid[i]  = '0;
            shadow_len[i]  = '0;
            shadow_hits[i] = '0;
            shadow_data[i] = '0;
        end
        shadow_free = 0;

        // Directed rows. Typed results: empty table after reset, zero key hitting
        // entry 0, all-ones key and data, length saturation, table full, interval end.
        add_row(mk_frame(FN_READ, 16'h0, 16'h0, 4'd0, 64'h0, 4'd0), 1'b1,
                mk_report(ST_READ, 4'd0, 5'd0, 16'h0, 16'h0, 8'd0, 4'd0, 64'h0));
        add_row(mk_frame(FN_RECORD, 16'h0, 16'h0, 4'd0, '1, 4'd0), 1'b1,
                mk_report(ST_HIT, 4'd0, 5'd1, 16'h0, 16'h0, 8'd1, 4'd0, 64'h0));
        add_row(mk_frame(FN_RECORD, 16'hFFFF, 16'hFFFF, 4'd8, '1, 4'd0), 1'b1,
                mk_report(ST_NEW, 4'd1, 5'd2, 16'hFFFF, 16'hFFFF, 8'd1, 4'd8, '1));
        add_row(mk_frame(FN_RECORD, 16'hFFFF, 16'hFFFF, 4'hF, 64'h0, 4'd0), 1'b1,
                mk_report(ST_HIT, 4'd1, 5'd2, 16'hFFFF, 16'hFFFF, 8'd2, 4'd8, 64'h0));
        // fill slots 2..15, lengths 2..15 so the oversize ones saturate
        for (int k = 2; k < TABLE_ENTRIES; k++)
            add_row(mk_frame(FN_RECORD, KEY_W'(k), ~KEY_W'(k), LEN_W'(k),
                             {$urandom, $urandom}, 4'd0), 1'b0, '0);
        add_row(mk_frame(FN_RECORD, 16'h1234, 16'h5678, 4'd8, {$urandom, $urandom}, 4'd0),
                1'b1, mk_report(ST_DROP, 4'd0, 5'd16, 16'h0, 16'h0, 8'd0, 4'd0, 64'h0));
        add_row(mk_frame(FN_READ, 16'h0, 16'h0, 4'd0, 64'h0, 4'hF), 1'b0, '0);
        add_row(mk_frame(FN_NONE, 16'hFFFF, 16'hFFFF, 4'hF, '1, 4'hF), 1'b0, '0);
        add_row(mk_frame(FN_CLEAR, 16'h0, 16'h0, 4'd0, 64'h0, 4'd0), 1'b1,
                mk_report(ST_CLEAR, 4'd0, 5'd0, 16'h0, 16'h0, 8'd0, 4'd0, 64'h0));
        // key still held by an entry idle since the interval end: still a hit
        add_row(mk_frame(FN_RECORD, 16'hFFFF, 16'hFFFF, 4'd1, 64'h0123_4567_89AB_CDEF, 4'd0),
                1'b0, '0);
        add_row(mk_frame(FN_CLEAR, 16'h0, 16'h0, 4'd0, 64'h0, 4'd0), 1'b0, '0);
        add_row(mk_frame(FN_READ, 16'h0, 16'h0, 4'd0, 64'h0, 4'd1), 1'b0, '0);
        add_row(mk_frame(FN_READ, 16'h0, 16'h0, 4'd0, 64'h0, 4'd5), 1'b0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            sender_gap();
            offer(dir_rows[r].frame, dir_rows[r].has_want, dir_rows[r].want);
        end
        drain();

        // Random chunks. Chunk 1 runs the long receiver hold-off with the sender
        // pushing back to back; chunk 2 opens a fresh interval and drives one key
        // to the count ceiling.
        counted = 0;
        chunk   = 0;
        while (counted < RAND_ITEMS) begin
            mix  = (chunk == 2) ? MIX_SAT : t_mix'($urandom_range(0, 2));
            calm = (chunk == 1) || ($urandom_range(0, 4) == 0);
            for (int i = 0; i < POOL_SIZE; i++)
                key_pool[i] = $urandom;
            if (chunk == 1)
                hold_req = 1'b1;
            if (chunk == 3 || $urandom_range(0, 3) == 0)
                drain();
            if (mix == MIX_SAT) begin
                // free every slot so the hammered key always finds one
                sender_gap();
                offer(mk_frame(FN_CLEAR, 16'h0, 16'h0, 4'd0, 64'h0, 4'd0), 1'b0, '0);
                counted++;
            end
            chunk_len = (mix == MIX_SAT) ? 400 : 80;
            for (int n = 0; n < chunk_len; n++) begin
                sender_gap();
                f = rand_frame(mix);
                offer(f, 1'b0, '0);
                if (f.func != FN_NONE)
                    counted++;
            end
            chunk++;
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (report_q.size() != 0)
            @(posedge i_clk);
        // catch anything the block sends that nobody asked for
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d transfers in, %0d results checked", frames_in, results_seen);
        $display("tb: %0d records, %0d reads, %0d interval ends, %0d ignored",
                 n_record, n_read, n_clear, n_ignored);
        $display("tb: %0d drops on a full table, %0d updates at the count ceiling",
                 n_drop, n_ceiling);
        $display("tb: %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
